[rtl/core/spfe_pkg.sv]
// ----------------------------------------------------------------------------
// spfe_pkg
// shared widths, constants and types of the speed loop pi controller
// ----------------------------------------------------------------------------
package spfe_pkg;

    localparam int SPEED_W   = 16;
    localparam int GAIN_W    = 24;
    localparam int DRIVE_W   = 32;
    localparam int ERR_W     = SPEED_W + 1;
    localparam int INTEG_W   = 15;
    localparam int INTEG_SUM_W = ERR_W + 1;

    // serial multiply-accumulate sizes
    localparam int MCAND_W   = GAIN_W;
    localparam int MPLR_W    = ERR_W;
    localparam int ACC_W     = MCAND_W + MPLR_W + 2;

    localparam int GAIN_FRAC_BITS_DEF = 12;

    // low-pass weights in q16, they sum to exactly one
    localparam int FILT_SHIFT = 16;
    localparam logic signed [MCAND_W-1:0] NEW_WEIGHT = MCAND_W'(19661);
    localparam logic signed [MCAND_W-1:0] OLD_WEIGHT = MCAND_W'(45875);

    localparam logic signed [INTEG_SUM_W-1:0] INTEG_LIMIT = INTEG_SUM_W'(10000);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN_A = 5'b00010,
        S_FILT  = 5'b00100,
        S_RUN_B = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

endpackage

[rtl/core/spfe_serial_mac.sv]
// ----------------------------------------------------------------------------
// spfe_serial_mac
// bit-serial dot product of two signed pairs, a*x + b*y, one multiplier bit
// of each pair per cycle, partial sum shifted right with low bits collected
// ----------------------------------------------------------------------------
module spfe_serial_mac #(
    parameter int MCAND_W = spfe_pkg::MCAND_W,
    parameter int MPLR_W  = spfe_pkg::MPLR_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [MCAND_W-1:0]         i_mcand_a,
    input  logic signed [MCAND_W-1:0]         i_mcand_b,
    input  logic signed [MPLR_W-1:0]          i_mplr_a,
    input  logic signed [MPLR_W-1:0]          i_mplr_b,
    output logic                              o_done,
    output logic signed [MCAND_W+MPLR_W+1:0]  o_product
);

    localparam int PW = MCAND_W + 2;
    localparam int CW = $clog2(MPLR_W);

    logic signed [PW-1:0]      r_p;
    logic        [MPLR_W-1:0]  r_lo;
    logic        [MPLR_W-1:0]  r_xa;
    logic        [MPLR_W-1:0]  r_xb;
    logic signed [MCAND_W-1:0] r_ma;
    logic signed [MCAND_W-1:0] r_mb;
    logic        [CW-1:0]      r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic                      last_bit;
    logic signed [PW-1:0]      ext_a;
    logic signed [PW-1:0]      ext_b;
    logic signed [PW-1:0]      term_a;
    logic signed [PW-1:0]      term_b;
    logic signed [PW-1:0]      n_p;

    always_comb begin
        last_bit = (r_cnt == CW'(MPLR_W - 1));
        ext_a    = {{2{r_ma[MCAND_W-1]}}, r_ma};
        ext_b    = {{2{r_mb[MCAND_W-1]}}, r_mb};
        // the sign bit of a two's complement multiplier weighs negative
        term_a   = r_xa[0] ? (last_bit ? -ext_a : ext_a) : '0;
        term_b   = r_xb[0] ? (last_bit ? -ext_b : ext_b) : '0;
        n_p      = r_p + term_a + term_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (last_bit) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p  <= '0;
            r_lo <= '0;
            r_ma <= i_mcand_a;
            r_mb <= i_mcand_b;
            r_xa <= i_mplr_a;
            r_xb <= i_mplr_b;
        end else if (r_busy) begin
            r_p  <= n_p >>> 1;
            r_lo <= {n_p[0], r_lo[MPLR_W-1:1]};
            r_xa <= {1'b0, r_xa[MPLR_W-1:1]};
            r_xb <= {1'b0, r_xb[MPLR_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_p, r_lo};

endmodule

[rtl/core/speed_pi_filtered_error.sv]
// ----------------------------------------------------------------------------
// speed_pi_filtered_error
// speed loop pi controller on a low-pass smoothed speed error. Each word
// brings a target and a measured speed; error = measured - target is smoothed
// as 0.3*error + 0.7*last (q16, truncated toward zero), summed into an integral
// that is cleared when it leaves +/-10000, and the drive output is
// (prop_gain*smoothed + integ_gain*integral) >> GAIN_FRAC_BITS, truncated
// toward zero and saturated to 32 bits. Items are handled one at a time: the
// input is ready again only after acceptance, a filter pass through the
// bit-serial multiply unit, the filter/integral update, a gains pass and the
// output load; each pass steps through all 17 multiplier bits, then signals
// done. A finished result waits in the output register while the next word
// is taken; a result that finds the output register still full holds the
// block until it drains. The user must write gains through the config port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module speed_pi_filtered_error #(
    parameter int GAIN_FRAC_BITS = spfe_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [spfe_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [spfe_pkg::GAIN_W-1:0]            i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [spfe_pkg::SPEED_W-1:0]    i_target_speed,
    input  logic signed [spfe_pkg::SPEED_W-1:0]    i_measured_speed,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [spfe_pkg::DRIVE_W-1:0]    o_drive_out
);

    localparam int ACC_W   = spfe_pkg::ACC_W;
    localparam int ERR_W   = spfe_pkg::ERR_W;
    localparam int INTEG_W = spfe_pkg::INTEG_W;
    localparam int ISUM_W  = spfe_pkg::INTEG_SUM_W;
    localparam int DRIVE_W = spfe_pkg::DRIVE_W;
    localparam int SH      = spfe_pkg::FILT_SHIFT;

    localparam logic [ACC_W-1:0] FILT_RND = {{(ACC_W-SH){1'b0}}, {SH{1'b1}}};
    localparam logic [ACC_W-1:0] GAIN_RND =
        {{(ACC_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

    spfe_pkg::t_state r_state, n_state;

    logic signed [spfe_pkg::GAIN_W-1:0]  r_prop_gain;
    logic signed [spfe_pkg::GAIN_W-1:0]  r_integ_gain;
    logic signed [ERR_W-1:0]             r_last;
    logic signed [INTEG_W-1:0]           r_integ;
    logic                                r_out_valid;
    logic signed [DRIVE_W-1:0]           r_drive_out;

    logic                                in_acc;
    logic                                mac_start;
    logic                                mac_done;
    logic                                is_filt;
    logic signed [spfe_pkg::MCAND_W-1:0] mcand_a;
    logic signed [spfe_pkg::MCAND_W-1:0] mcand_b;
    logic signed [ERR_W-1:0]             mplr_a;
    logic signed [ERR_W-1:0]             mplr_b;
    logic signed [ACC_W-1:0]             product;

    logic signed [ERR_W-1:0]             err;
    logic signed [ACC_W-1:0]             filt_adj;
    logic signed [ERR_W-1:0]             filt;
    logic signed [ISUM_W-1:0]            isum;
    logic signed [INTEG_W-1:0]           integ;
    logic signed [ACC_W-1:0]             drive_adj;
    logic signed [ACC_W-1:0]             drive_sh;
    logic signed [DRIVE_W-1:0]           drive_sat;
    logic                                out_load;

    assign o_in_ready = (r_state == spfe_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_filt    = (r_state == spfe_pkg::S_FILT);
    assign mac_start  = in_acc || is_filt;
    assign out_load   = (r_state == spfe_pkg::S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        err = ERR_W'(i_measured_speed) - ERR_W'(i_target_speed);

        // smoothed error, q16 product truncated toward zero
        filt_adj = product + (product[ACC_W-1] ? FILT_RND : '0);
        filt     = filt_adj[SH+ERR_W-1:SH];

        isum  = ISUM_W'(r_integ) + ISUM_W'(filt);
        integ = ((isum > spfe_pkg::INTEG_LIMIT) || (isum < -spfe_pkg::INTEG_LIMIT))
              ? '0 : isum[INTEG_W-1:0];

        mcand_a = is_filt ? r_prop_gain  : spfe_pkg::NEW_WEIGHT;
        mcand_b = is_filt ? r_integ_gain : spfe_pkg::OLD_WEIGHT;
        mplr_a  = is_filt ? filt : err;
        mplr_b  = is_filt ? ERR_W'(integ) : r_last;

        drive_adj = product + (product[ACC_W-1] ? GAIN_RND : '0);
        drive_sh  = drive_adj >>> GAIN_FRAC_BITS;
        if (!drive_sh[ACC_W-1] && (drive_sh[ACC_W-2:DRIVE_W-1] != '0)) begin
            drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
        end else if (drive_sh[ACC_W-1] && (drive_sh[ACC_W-2:DRIVE_W-1] != '1)) begin
            drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            drive_sat = drive_sh[DRIVE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            spfe_pkg::S_IDLE:  if (in_acc)   n_state = spfe_pkg::S_RUN_A;
            spfe_pkg::S_RUN_A: if (mac_done) n_state = spfe_pkg::S_FILT;
            spfe_pkg::S_FILT:                n_state = spfe_pkg::S_RUN_B;
            spfe_pkg::S_RUN_B: if (mac_done) n_state = spfe_pkg::S_FIN;
            spfe_pkg::S_FIN:   if (out_load) n_state = spfe_pkg::S_IDLE;
            default:                         n_state = spfe_pkg::S_IDLE;
        endcase
    end

    spfe_serial_mac #(
        .MCAND_W (spfe_pkg::MCAND_W),
        .MPLR_W  (spfe_pkg::MPLR_W)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mac_start),
        .i_mcand_a (mcand_a),
        .i_mcand_b (mcand_b),
        .i_mplr_a  (mplr_a),
        .i_mplr_b  (mplr_b),
        .o_done    (mac_done),
        .o_product (product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= spfe_pkg::S_IDLE;
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_last       <= '0;
            r_integ      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    spfe_pkg::CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                    spfe_pkg::CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (is_filt) begin
                r_last  <= filt;
                r_integ <= integ;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_drive_out <= drive_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive_out = r_drive_out;

endmodule
